// ----- rtl/ddct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddct_pkg
// Shared constants, codes and types of the dual down-counter timer block.
// ----------------------------------------------------------------------------
package ddct_pkg;

	localparam int NUM_TIMERS  = 2;
	localparam int COUNT_WIDTH = 56;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = 8;
	localparam int HI_W        = COUNT_WIDTH - DATA_W;
	localparam int OFF_W       = 5;
	localparam int SEL_W       = ADDR_W - OFF_W;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2
	} ddct_func_t;

	// global registers
	localparam logic [ADDR_W-1:0] ADDR_IRQ_EN = 8'h00;
	localparam logic [ADDR_W-1:0] ADDR_IRQ_ST = 8'h04;

	// offsets within a timer window
	localparam logic [OFF_W-1:0] OFF_CTRL   = 5'h00;
	localparam logic [OFF_W-1:0] OFF_IVL_LO = 5'h04;
	localparam logic [OFF_W-1:0] OFF_CNT_LO = 5'h08;
	localparam logic [OFF_W-1:0] OFF_IVL_HI = 5'h0c;
	localparam logic [OFF_W-1:0] OFF_CNT_HI = 5'h10;

	// control word bits
	localparam int CTL_EN_BIT      = 0;
	localparam int CTL_RELOAD_BIT  = 1;
	localparam int CTL_ONESHOT_BIT = 7;

	typedef struct packed {
		logic              tick;  // advancing tick word
		logic              wr;    // advancing write aimed at this timer
		logic              sel;   // address falls in this timer window
		logic [OFF_W-1:0]  off;
		logic [DATA_W-1:0] wdata;
	} ddct_tmr_cmd_t;

endpackage

// ----- rtl/ddct_cmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddct_cmd_if
// Command channel: tick, register read or register write.
// ----------------------------------------------------------------------------
interface ddct_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  reg_address;
	logic [31:0] write_data;

	modport source (output valid, func, reg_address, write_data, input ready);
	modport sink   (input valid, func, reg_address, write_data, output ready);
endinterface

// ----- rtl/ddct_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddct_rsp_if
// Response channel: read data and interrupt level after each command.
// ----------------------------------------------------------------------------
interface ddct_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        irq_pending;

	modport source (output valid, read_data, irq_pending, input ready);
	modport sink   (input valid, read_data, irq_pending, output ready);
endinterface

// ----- rtl/ddct_timer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddct_timer
// One down counter with interval, control bits, register access and expiry.
// ----------------------------------------------------------------------------
module ddct_timer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ddct_pkg::ddct_tmr_cmd_t    cmd,
	output logic [ddct_pkg::DATA_W-1:0] rdata,
	output logic                       expire
);

	logic                               en_q;
	logic                               os_q;
	logic [ddct_pkg::COUNT_WIDTH-1:0]   ivl_q;
	logic [ddct_pkg::COUNT_WIDTH-1:0]   cnt_q;
	logic                               at_end;

	// an enabled count of one or zero expires on the next tick
	assign at_end = (cnt_q[ddct_pkg::COUNT_WIDTH-1:1] == '0);
	assign expire = cmd.tick && en_q && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			os_q  <= 1'b0;
			ivl_q <= '0;
			cnt_q <= '0;
		end else if (cmd.tick) begin
			if (en_q) begin
				if (at_end) begin
					if (os_q) begin
						cnt_q <= '0;
						en_q  <= 1'b0;
					end else begin
						cnt_q <= ivl_q;
					end
				end else begin
					cnt_q <= cnt_q - ddct_pkg::COUNT_WIDTH'(1);
				end
			end
		end else if (cmd.wr) begin
			unique case (cmd.off)
				ddct_pkg::OFF_CTRL: begin
					en_q <= cmd.wdata[ddct_pkg::CTL_EN_BIT];
					os_q <= cmd.wdata[ddct_pkg::CTL_ONESHOT_BIT];
					if (cmd.wdata[ddct_pkg::CTL_RELOAD_BIT]) begin
						cnt_q <= ivl_q;
					end
				end
				ddct_pkg::OFF_IVL_LO: begin
					ivl_q[ddct_pkg::DATA_W-1:0] <= cmd.wdata;
				end
				ddct_pkg::OFF_CNT_LO: begin
					cnt_q[ddct_pkg::DATA_W-1:0] <= cmd.wdata;
				end
				ddct_pkg::OFF_IVL_HI: begin
					ivl_q[ddct_pkg::COUNT_WIDTH-1:ddct_pkg::DATA_W] <=
						cmd.wdata[ddct_pkg::HI_W-1:0];
				end
				ddct_pkg::OFF_CNT_HI: begin
					cnt_q[ddct_pkg::COUNT_WIDTH-1:ddct_pkg::DATA_W] <=
						cmd.wdata[ddct_pkg::HI_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		rdata = '0;
		if (cmd.sel) begin
			unique case (cmd.off)
				ddct_pkg::OFF_CTRL: begin
					rdata[ddct_pkg::CTL_EN_BIT]      = en_q;
					rdata[ddct_pkg::CTL_ONESHOT_BIT] = os_q;
				end
				ddct_pkg::OFF_IVL_LO: rdata = ivl_q[ddct_pkg::DATA_W-1:0];
				ddct_pkg::OFF_CNT_LO: rdata = cnt_q[ddct_pkg::DATA_W-1:0];
				ddct_pkg::OFF_IVL_HI:
					rdata = ddct_pkg::DATA_W'(ivl_q[ddct_pkg::COUNT_WIDTH-1:ddct_pkg::DATA_W]);
				ddct_pkg::OFF_CNT_HI:
					rdata = ddct_pkg::DATA_W'(cnt_q[ddct_pkg::COUNT_WIDTH-1:ddct_pkg::DATA_W]);
				default: rdata = '0;
			endcase
		end
	end

endmodule

// ----- rtl/dual_down_counter_timer_regs_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_down_counter_timer_regs_core
// Register-mapped block of down-counting interval timers with reload,
// interrupt enable and write-one-to-clear status.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | word
//  cmd     | in  | valid/ready   | func, reg_address, write_data
//  rsp     | out | valid/ready   | read_data, irq_pending
//
//  Each word is taken into the input register; the state update and
//  the result are formed there and land in the output register, from
//  which the word is answered; one word is taken per cycle unless rsp stalls.
//  Reset clears all timers and interrupt registers; no clearing pass.
//  A stalled response holds the input register; cmd.ready drops only while
//  both registers are full and rsp.ready is low.
// ----------------------------------------------------------------------------
module dual_down_counter_timer_regs_core (
	input  logic       clk,
	input  logic       arst_n,
	ddct_cmd_if.sink   cmd,
	ddct_rsp_if.source rsp
);

	// input register
	logic                          vld_s1;
	logic [1:0]                    func_s1;
	logic [ddct_pkg::ADDR_W-1:0]   addr_s1;
	logic [ddct_pkg::DATA_W-1:0]   wdata_s1;

	// output register
	logic                          out_vld_q;
	logic [ddct_pkg::DATA_W-1:0]   rdata_q;
	logic                          irq_q;

	logic [ddct_pkg::NUM_TIMERS-1:0] irq_en_q;
	logic [ddct_pkg::NUM_TIMERS-1:0] irq_st_q;
	logic [ddct_pkg::NUM_TIMERS-1:0] en_nxt;
	logic [ddct_pkg::NUM_TIMERS-1:0] st_nxt;

	logic                          adv;
	logic                          is_tick;
	logic                          is_read;
	logic                          is_write;
	logic [ddct_pkg::NUM_TIMERS-1:0] tmr_sel;
	logic [ddct_pkg::NUM_TIMERS-1:0] expire;
	logic [ddct_pkg::DATA_W-1:0]   tmr_rdata [ddct_pkg::NUM_TIMERS];
	logic [ddct_pkg::DATA_W-1:0]   tmr_rd_any;
	logic [ddct_pkg::DATA_W-1:0]   rd_nxt;

	assign adv       = vld_s1 && (!out_vld_q || rsp.ready);
	assign cmd.ready = !vld_s1 || adv;

	assign is_tick  = (func_s1 == ddct_pkg::FUNC_TICK);
	assign is_read  = (func_s1 == ddct_pkg::FUNC_READ);
	assign is_write = (func_s1 == ddct_pkg::FUNC_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			func_s1  <= cmd.func;
			addr_s1  <= cmd.reg_address;
			wdata_s1 <= cmd.write_data;
		end
	end

	generate
		for (genvar i = 0; i < ddct_pkg::NUM_TIMERS; i++) begin : g_tmr
			ddct_pkg::ddct_tmr_cmd_t tcmd;

			// window n sits at 0x20*n+0x20
			assign tmr_sel[i]  = (addr_s1[ddct_pkg::ADDR_W-1:ddct_pkg::OFF_W] ==
				ddct_pkg::SEL_W'(i + 1));
			assign tcmd.tick   = adv && is_tick;
			assign tcmd.wr     = adv && is_write && tmr_sel[i];
			assign tcmd.sel    = tmr_sel[i];
			assign tcmd.off    = addr_s1[ddct_pkg::OFF_W-1:0];
			assign tcmd.wdata  = wdata_s1;

			ddct_timer u_tmr (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (tcmd),
				.rdata  (tmr_rdata[i]),
				.expire (expire[i])
			);
		end
	endgenerate

	always_comb begin
		tmr_rd_any = '0;
		for (int i = 0; i < ddct_pkg::NUM_TIMERS; i++) begin
			tmr_rd_any = tmr_rd_any | tmr_rdata[i];
		end
	end

	always_comb begin
		en_nxt = irq_en_q;
		st_nxt = irq_st_q;
		if (adv && is_tick) begin
			st_nxt = irq_st_q | expire;
		end
		if (adv && is_write && addr_s1 == ddct_pkg::ADDR_IRQ_EN) begin
			en_nxt = wdata_s1[ddct_pkg::NUM_TIMERS-1:0];
		end
		if (adv && is_write && addr_s1 == ddct_pkg::ADDR_IRQ_ST) begin
			st_nxt = irq_st_q & ~wdata_s1[ddct_pkg::NUM_TIMERS-1:0];
		end
	end

	always_comb begin
		priority if (!is_read) begin
			rd_nxt = '0;
		end else if (addr_s1 == ddct_pkg::ADDR_IRQ_EN) begin
			rd_nxt = ddct_pkg::DATA_W'(irq_en_q);
		end else if (addr_s1 == ddct_pkg::ADDR_IRQ_ST) begin
			rd_nxt = ddct_pkg::DATA_W'(irq_st_q);
		end else begin
			rd_nxt = tmr_rd_any;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_en_q  <= '0;
			irq_st_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			irq_en_q <= en_nxt;
			irq_st_q <= st_nxt;
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_q <= rd_nxt;
			irq_q   <= |(st_nxt & en_nxt);
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.read_data   = rdata_q;
	assign rsp.irq_pending = irq_q;

	// interrupt level shown with a valid response matches the live registers
	a_irq_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (rsp.irq_pending == |(irq_st_q & irq_en_q)))
		else $error("irq_pending out of step with status/enable");

	// only reads return data
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !is_read) |=> (rsp.read_data == '0))
		else $error("nonzero read_data for a non-read word");

	a_sel_one: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $onehot0(tmr_sel))
		else $error("more than one timer window decoded");

	// expiry only on an advancing tick
	a_expire_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(|expire) |-> (adv && is_tick))
		else $error("timer expiry outside a tick");

endmodule
